// ===== rtl/core/ahfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ahfr_pkg
// Shared types and constants of the ASCII hex frame receiver core.
// ----------------------------------------------------------------------------
package ahfr_pkg;

  localparam int unsigned MaxFrameBytesDefault = 512;

  localparam int CharW    = 8;
  localparam int ResKindW = 2;
  localparam int DataW    = 8;
  localparam int PosW     = 9;
  localparam int LenW     = 10;
  localparam int IdleW    = 16;
  localparam int CfgW     = 16;

  localparam logic [IdleW-1:0] IdleLimitReset = 16'd100;

  localparam logic [CharW-1:0] CharColon     = 8'h3A;
  localparam logic [CharW-1:0] CharNewline   = 8'h0A;
  localparam logic [CharW-1:0] CharZero      = 8'd48;
  localparam logic [CharW-1:0] CharNine      = 8'd57;
  localparam logic [CharW-1:0] CharUpperA    = 8'd65;
  localparam logic [CharW-1:0] CharUpperF    = 8'd70;
  localparam logic [CharW-1:0] HexLetterBias = 8'd55;

  typedef enum logic [0:0] {
    KIND_CHAR = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_t;

  typedef enum logic [0:0] {
    CFG_PORT_ENABLE = 1'b0,
    CFG_IDLE_LIMIT  = 1'b1
  } cfg_index_t;

  // classified word handed from front to back
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_COLON   = 2'd1,
    OP_NEWLINE = 2'd2,
    OP_NIBBLE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] nibble;
  } cmd_t;

  typedef enum logic [ResKindW-1:0] {
    RK_DATA  = 2'd0,
    RK_END   = 2'd1,
    RK_ABORT = 2'd2
  } result_kind_t;

  typedef struct packed {
    result_kind_t    kind;
    logic [DataW-1:0] data_byte;
    logic [PosW-1:0]  byte_position;
    logic [LenW-1:0]  frame_length;
    logic             lrc_ok;
  } result_t;

endpackage

// ===== rtl/core/ahfr_ifs.sv =====
// ----------------------------------------------------------------------------
// ahfr_ifs
// Valid/ready channels of the receiver: received words in, results out.
// ----------------------------------------------------------------------------
interface ahfr_char_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [ahfr_pkg::CharW-1:0] character;

  modport source (output valid, output kind, output character, input ready);
  modport sink   (input valid, input kind, input character, output ready);
endinterface

interface ahfr_result_if;
  logic                          valid;
  logic                          ready;
  logic [ahfr_pkg::ResKindW-1:0] result_kind;
  logic [ahfr_pkg::DataW-1:0]    data_byte;
  logic [ahfr_pkg::PosW-1:0]     byte_position;
  logic [ahfr_pkg::LenW-1:0]     frame_length;
  logic                          lrc_ok;

  modport source (output valid, output result_kind, output data_byte,
                  output byte_position, output frame_length, output lrc_ok,
                  input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input byte_position, input frame_length, input lrc_ok,
                  output ready);
endinterface

// ===== rtl/core/ahfr_front.sv =====
// ----------------------------------------------------------------------------
// ahfr_front
// Accepts incoming words and classifies them into queue commands.
// ----------------------------------------------------------------------------
module ahfr_front (
  input  logic             port_enable,
  ahfr_char_if.sink        chars,
  input  logic             queue_full,
  output logic             push,
  output ahfr_pkg::cmd_t   cmd
);
  import ahfr_pkg::*;

  logic [CharW-1:0] ch;
  logic [3:0]       nibble;

  assign ch = chars.character;
  assign chars.ready = !queue_full;

  // anything that is not an uppercase hex digit counts as zero
  always_comb begin
    nibble = 4'd0;
    if (ch >= CharZero && ch <= CharNine) begin
      nibble = 4'(ch - CharZero);
    end else if (ch >= CharUpperA && ch <= CharUpperF) begin
      nibble = 4'(ch - HexLetterBias);
    end
  end

  always_comb begin
    cmd.nibble = nibble;
    if (item_kind_t'(chars.kind) == KIND_TICK) begin
      cmd.op = OP_TICK;
    end else if (ch == CharColon) begin
      cmd.op = OP_COLON;
    end else if (ch == CharNewline) begin
      cmd.op = OP_NEWLINE;
    end else begin
      cmd.op = OP_NIBBLE;
    end
  end

  // words taken while the port is disabled are dropped here
  assign push = chars.valid && !queue_full && port_enable;

endmodule

// ===== rtl/core/ahfr_queue.sv =====
// ----------------------------------------------------------------------------
// ahfr_queue
// Two-entry command queue between the classifier and the frame engine.
// ----------------------------------------------------------------------------
module ahfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ahfr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output ahfr_pkg::cmd_t head
);
  import ahfr_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/ahfr_back.sv =====
// ----------------------------------------------------------------------------
// ahfr_back
// Frame engine: packs nibbles into bytes, tracks the LRC and the idle
// timeout, and holds the result register.
// ----------------------------------------------------------------------------
module ahfr_back #(
  parameter int unsigned MAX_FRAME_BYTES = ahfr_pkg::MaxFrameBytesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ahfr_pkg::IdleW-1:0]    idle_limit,
  input  logic                          cmd_valid,
  input  ahfr_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  ahfr_result_if.source                 results
);
  import ahfr_pkg::*;

  localparam int CountW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_FRAME_BYTES);

  logic              in_frame, in_frame_next;
  logic              half_pending, half_pending_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [DataW-1:0]  sum_before_last, sum_before_last_next;
  logic [DataW-1:0]  last_byte, last_byte_next;
  logic [IdleW-1:0]  idle_count, idle_count_next;

  logic              out_valid;
  result_t           out_word, out_word_next;
  logic              emit;
  logic              fire;
  logic [IdleW-1:0]  limit;
  logic [IdleW-1:0]  idle_inc;
  logic [DataW-1:0]  new_byte;

  assign fire    = cmd_valid && (!out_valid || results.ready);
  assign cmd_pop = fire;
  assign limit   = (idle_limit == '0) ? IdleW'(1) : idle_limit;
  assign idle_inc = (idle_count != '1) ? idle_count + IdleW'(1) : idle_count;
  assign new_byte = {high_nibble, cmd.nibble};

  always_comb begin
    in_frame_next        = in_frame;
    half_pending_next    = half_pending;
    high_nibble_next     = high_nibble;
    byte_count_next      = byte_count;
    sum_before_last_next = sum_before_last;
    last_byte_next       = last_byte;
    idle_count_next      = idle_count;
    emit                 = 1'b0;
    out_word_next        = '0;
    out_word_next.kind   = RK_ABORT;

    if (fire) begin
      unique case (cmd.op)
        OP_TICK: begin
          if (in_frame) begin
            if (idle_inc >= limit) begin
              emit          = 1'b1;
              in_frame_next = 1'b0;
              half_pending_next    = 1'b0;
              high_nibble_next     = '0;
              byte_count_next      = '0;
              sum_before_last_next = '0;
              last_byte_next       = '0;
              idle_count_next      = '0;
            end else begin
              idle_count_next = idle_inc;
            end
          end
        end
        OP_COLON: begin
          // a colon always opens a fresh frame; inside a frame it aborts first
          emit          = in_frame;
          in_frame_next = 1'b1;
          half_pending_next    = 1'b0;
          high_nibble_next     = '0;
          byte_count_next      = '0;
          sum_before_last_next = '0;
          last_byte_next       = '0;
          idle_count_next      = '0;
        end
        OP_NEWLINE: begin
          if (in_frame) begin
            emit                       = 1'b1;
            out_word_next.kind         = RK_END;
            out_word_next.frame_length = LenW'(byte_count);
            out_word_next.lrc_ok       = (byte_count != '0) &&
                                         (sum_before_last == last_byte);
            in_frame_next        = 1'b0;
            half_pending_next    = 1'b0;
            high_nibble_next     = '0;
            byte_count_next      = '0;
            sum_before_last_next = '0;
            last_byte_next       = '0;
            idle_count_next      = '0;
          end
        end
        OP_NIBBLE: begin
          if (in_frame) begin
            idle_count_next = '0;
            if (!half_pending) begin
              high_nibble_next  = cmd.nibble;
              half_pending_next = 1'b1;
            end else begin
              half_pending_next = 1'b0;
              high_nibble_next  = '0;
              emit              = 1'b1;
              if (byte_count >= MaxCount) begin
                // frame too long
                in_frame_next        = 1'b0;
                byte_count_next      = '0;
                sum_before_last_next = '0;
                last_byte_next       = '0;
              end else begin
                if (byte_count != '0) begin
                  sum_before_last_next = sum_before_last + last_byte;
                end
                last_byte_next              = new_byte;
                byte_count_next             = byte_count + CountW'(1);
                out_word_next.kind          = RK_DATA;
                out_word_next.data_byte     = new_byte;
                out_word_next.byte_position = PosW'(byte_count);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      half_pending    <= 1'b0;
      high_nibble     <= '0;
      byte_count      <= '0;
      sum_before_last <= '0;
      last_byte       <= '0;
      idle_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      in_frame        <= in_frame_next;
      half_pending    <= half_pending_next;
      high_nibble     <= high_nibble_next;
      byte_count      <= byte_count_next;
      sum_before_last <= sum_before_last_next;
      last_byte       <= last_byte_next;
      idle_count      <= idle_count_next;
      if (fire) begin
        out_valid <= emit;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_word <= out_word_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.result_kind   = out_word.kind;
  assign results.data_byte     = out_word.data_byte;
  assign results.byte_position = out_word.byte_position;
  assign results.frame_length  = out_word.frame_length;
  assign results.lrc_ok        = out_word.lrc_ok;

endmodule

// ===== rtl/core/ascii_hex_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver_core
// Receive side of ASCII hex framing: ':' opens a frame, hex pairs become
// bytes, newline closes it with length and LRC flag, timeouts abort it.
//
//   channel   dir   handshake         word
//   chars     in    valid/ready       kind, character
//   results   out   valid/ready       result_kind, data_byte, byte_position,
//                                     frame_length, lrc_ok
//   cfg       in    cfg_write         cfg_index, cfg_data
//
// one word per cycle while results are taken; a taken word passes through the
// command queue, and its result shows from the result register of the frame engine
// a two-entry command queue sits between classifier and frame engine, so
// chars.ready drops only when the queue is full behind a stalled result
// reset: port enabled, idle limit 100, no open frame, queue empty
// ----------------------------------------------------------------------------
module ascii_hex_frame_receiver_core #(
  parameter int unsigned MAX_FRAME_BYTES = ahfr_pkg::MaxFrameBytesDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [ahfr_pkg::CfgW-1:0]  cfg_data,
  ahfr_char_if.sink                  chars,
  ahfr_result_if.source              results
);
  import ahfr_pkg::*;

  logic             port_enable;
  logic [IdleW-1:0] idle_limit;
  logic             push;
  cmd_t             push_cmd;
  logic             queue_full;
  logic             queue_not_empty;
  cmd_t             head;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_enable <= 1'b1;
      idle_limit  <= IdleLimitReset;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PORT_ENABLE: port_enable <= cfg_data[0];
        CFG_IDLE_LIMIT:  idle_limit  <= cfg_data[IdleW-1:0];
        default: begin
        end
      endcase
    end
  end

  ahfr_front u_front (
    .port_enable (port_enable),
    .chars       (chars),
    .queue_full  (queue_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  ahfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  ahfr_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .idle_limit (idle_limit),
    .cmd_valid  (queue_not_empty),
    .cmd        (head),
    .cmd_pop    (pop),
    .results    (results)
  );

endmodule

// ===== dv/tb_ascii_hex_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// tb_ascii_hex_frame_receiver_core
// Self-checking bench for the ASCII hex frame receiver. A behavioral model of
// the framing rules runs on every word the core takes, and its result words
// queue up against the core's output. A short directed table comes first,
// then port disable, an overlong frame, a long idle timeout, and random
// frames under several idle limits. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_ascii_hex_frame_receiver_core;
  import ahfr_pkg::*;

  localparam int DrainCycles = 8;
  localparam int MaxBytes    = MaxFrameBytesDefault;
  localparam int LongIdle    = 40;

  typedef struct {
    item_kind_t       kind;
    logic [CharW-1:0] ch;
    bit               typed;
    bit               has;
    result_t          res;
  } step_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [0:0]          cfg_index;
  logic [CfgW-1:0]     cfg_data;

  ahfr_char_if   chars_if ();
  ahfr_result_if results_if ();

  ascii_hex_frame_receiver_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chars     (chars_if),
    .results   (results_if)
  );

  // model copy of registers and frame state
  logic             m_port_en;
  logic [IdleW-1:0] m_idle_limit;
  logic             f_open;
  logic             f_half;
  logic [3:0]       f_hi;
  logic [LenW-1:0]  f_count;
  logic [7:0]       f_sum;
  logic [7:0]       f_last;
  logic [IdleW-1:0] f_idle;

  result_t   pending_results[$];
  step_row_t stim_rows[$];
  int        words_taken = 0;
  int        mismatches  = 0;
  int        burst_left  = 0;
  int        frame_words = 0;
  logic [15:0] stall_pattern = '1;
  logic [11:0] stall_tick    = '0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_frame_state();
    f_half  = 1'b0;
    f_hi    = '0;
    f_count = '0;
    f_sum   = '0;
    f_last  = '0;
    f_idle  = '0;
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [CharW-1:0] c);
    if (c >= CharZero && c <= CharNine) return 4'(c - CharZero);
    if (c >= CharUpperA && c <= CharUpperF) return 4'(c - HexLetterBias);
    return 4'd0;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CharZero + CharW'(n) : HexLetterBias + CharW'(n);
  endfunction

  // advances the frame model by one word, returns 1 when a result word follows
  function automatic bit frame_rx_predict(input logic k, input logic [CharW-1:0] c,
                                          output result_t r);
    logic [IdleW-1:0] lim;
    logic [7:0]       b;
    r = '0;
    if (!m_port_en) return 1'b0;
    if (k == KIND_TICK) begin
      lim = (m_idle_limit == '0) ? IdleW'(1) : m_idle_limit;
      if (!f_open) return 1'b0;
      if (f_idle != '1) f_idle = f_idle + IdleW'(1);
      if (f_idle >= lim) begin
        f_open = 1'b0;
        clear_frame_state();
        r.kind = RK_ABORT;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!f_open) begin
      if (c == CharColon) begin
        f_open = 1'b1;
        clear_frame_state();
      end
      return 1'b0;
    end
    f_idle = '0;
    if (c == CharColon) begin
      clear_frame_state();
      r.kind = RK_ABORT;
      return 1'b1;
    end
    if (c == CharNewline) begin
      r.kind         = RK_END;
      r.frame_length = f_count;
      r.lrc_ok       = (f_count != '0) && (f_sum == f_last);
      f_open = 1'b0;
      clear_frame_state();
      return 1'b1;
    end
    if (!f_half) begin
      f_hi   = hex_nibble(c);
      f_half = 1'b1;
      return 1'b0;
    end
    b      = {f_hi, hex_nibble(c)};
    f_half = 1'b0;
    f_hi   = '0;
    if (f_count >= LenW'(MaxBytes)) begin
      f_open = 1'b0;
      clear_frame_state();
      r.kind = RK_ABORT;
      return 1'b1;
    end
    if (f_count != '0) f_sum = f_sum + f_last;
    f_last          = b;
    r.kind          = RK_DATA;
    r.data_byte     = b;
    r.byte_position = f_count[PosW-1:0];
    f_count         = f_count + LenW'(1);
    return 1'b1;
  endfunction

  function automatic void report(input string what, input result_t got, input result_t want);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: got kind %0d byte %02h pos %0d len %0d lrc %0b, ",
                "want kind %0d byte %02h pos %0d len %0d lrc %0b"},
               $time, what, got.kind, got.data_byte, got.byte_position, got.frame_length,
               got.lrc_ok, want.kind, want.data_byte, want.byte_position, want.frame_length,
               want.lrc_ok);
  endfunction

  // result words are checked first, then the word taken at this edge is modeled
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    result_t pred;
    bit      fires;
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        got.kind          = result_kind_t'(results_if.result_kind);
        got.data_byte     = results_if.data_byte;
        got.byte_position = results_if.byte_position;
        got.frame_length  = results_if.frame_length;
        got.lrc_ok        = results_if.lrc_ok;
        if (pending_results.size() == 0) begin
          report("unexpected result", got, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.byte_position !== want.byte_position ||
              got.frame_length !== want.frame_length || got.lrc_ok !== want.lrc_ok)
            report("result mismatch", got, want);
        end
      end
      if (chars_if.valid && chars_if.ready) begin
        fires = frame_rx_predict(chars_if.kind, chars_if.character, pred);
        if (words_taken < stim_rows.size() && stim_rows[words_taken].typed) begin
          if (stim_rows[words_taken].has) pending_results.push_back(stim_rows[words_taken].res);
        end else if (fires) begin
          pending_results.push_back(pred);
        end
        words_taken++;
      end
    end
  end

  // receiver stall pattern, reshuffled whenever the low byte of stall_tick wraps, sometimes no stalls
  always @(posedge clk) begin
    stall_tick <= stall_tick + 12'd1;
    if (stall_tick[7:0] == 8'd0)
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0101;
    results_if.ready <= stall_pattern[stall_tick[3:0]];
  end

  task automatic send_word(input item_kind_t k, input logic [CharW-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        chars_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    chars_if.valid     <= 1'b1;
    chars_if.kind      <= k;
    chars_if.character <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_PORT_ENABLE) m_port_en = val[0];
    else m_idle_limit = val;
    @(posedge clk);
  endtask

  task automatic row_quiet(input item_kind_t k, input logic [CharW-1:0] c, input bit typed);
    step_row_t row;
    row.kind  = k;
    row.ch    = c;
    row.typed = typed;
    row.has   = 1'b0;
    row.res   = '0;
    stim_rows.push_back(row);
  endtask

  task automatic row_result(input logic [CharW-1:0] c, input result_kind_t rk,
                            input logic [7:0] d, input logic [PosW-1:0] p,
                            input logic [LenW-1:0] n, input logic ok);
    step_row_t row;
    row.kind              = KIND_CHAR;
    row.ch                = c;
    row.typed             = 1'b1;
    row.has               = 1'b1;
    row.res.kind          = rk;
    row.res.data_byte     = d;
    row.res.byte_position = p;
    row.res.frame_length  = n;
    row.res.lrc_ok        = ok;
    stim_rows.push_back(row);
  endtask

  // ticks ahead of a character: mostly below the limit, rarely enough to time out
  task automatic maybe_idle();
    int safe;
    int pick;
    safe = (m_idle_limit > 21) ? 20 : int'(m_idle_limit) - 1;
    pick = $urandom_range(0, 59);
    if (pick < 8 && safe > 0)
      repeat ($urandom_range(1, safe)) send_word(KIND_TICK, 8'($urandom));
    else if (pick == 8 && m_idle_limit <= 64)
      repeat (m_idle_limit) send_word(KIND_TICK, 8'($urandom));
  endtask

  task automatic send_digit(input logic [3:0] n, input bit clean);
    logic [CharW-1:0] c;
    c = hex_char(n);
    if (!clean) begin
      maybe_idle();
      case ($urandom_range(0, 23))
        0: c = 8'($urandom) | 8'h80;
        1: begin
          c = 8'($urandom_range(0, 47));
          if (c == CharNewline) c = 8'h00;
        end
        2: c = hex_char(n) + 8'd32;  // lowercase letter or other non-hex
        default: ;
      endcase
    end
    send_word(KIND_CHAR, c);
  endtask

  task automatic send_pair(input logic [7:0] val, input bit clean);
    send_digit(val[7:4], clean);
    send_digit(val[3:0], clean);
  endtask

  task automatic send_random_frame();
    int         nbytes;
    int         ending;
    bit         good_lrc;
    logic [7:0] val;
    logic [7:0] run_sum;
    nbytes   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    good_lrc = $urandom_range(0, 1);
    run_sum  = '0;
    send_word(KIND_CHAR, CharColon);
    for (int i = 0; i < nbytes; i++) begin
      val = 8'($urandom);
      if (good_lrc && i == nbytes - 1) val = run_sum;
      run_sum = run_sum + val;
      send_pair(val, 1'b0);
    end
    ending = $urandom_range(0, 99);
    if (ending < 78) begin
      maybe_idle();
      send_word(KIND_CHAR, CharNewline);
    end else if (ending < 88) begin
      send_digit(4'($urandom), 1'b0);
      send_word(KIND_CHAR, CharNewline);
    end else if (ending >= 94) begin
      send_word(KIND_CHAR, CharColon);
    end
    frame_words += 2 * nbytes + 2;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4))
        send_word(item_kind_t'($urandom_range(0, 1)), 8'($urandom));
  endtask

  task automatic run_random(input int target);
    frame_words = 0;
    while (frame_words < target) send_random_frame();
  endtask

  task automatic send_long_frame(input int npairs, input bit close);
    send_word(KIND_CHAR, CharColon);
    repeat (npairs) send_pair(8'($urandom), 1'b1);
    if (close) send_word(KIND_CHAR, CharNewline);
  endtask

  initial begin
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = CFG_PORT_ENABLE;
    cfg_data           = '0;
    chars_if.valid     = 1'b0;
    chars_if.kind      = KIND_CHAR;
    chars_if.character = '0;
    results_if.ready   = 1'b0;
    m_port_en          = 1'b1;
    m_idle_limit       = IdleLimitReset;
    f_open             = 1'b0;
    clear_frame_state();

    // directed table: outside-frame noise, extremes, invalid hex, empty frame,
    // good lrc with dangling nibble, restart on a second colon
    row_quiet(KIND_CHAR, 8'h00, 1'b1);
    row_quiet(KIND_TICK, 8'hFF, 1'b1);
    row_quiet(KIND_CHAR, CharColon, 1'b1);
    row_quiet(KIND_CHAR, hex_char(4'hF), 1'b1);
    row_result(hex_char(4'hF), RK_DATA, 8'hFF, 9'd0, 10'd0, 1'b0);
    row_quiet(KIND_CHAR, hex_char(4'h0), 1'b1);
    row_result(hex_char(4'h0), RK_DATA, 8'h00, 9'd1, 10'd0, 1'b0);
    row_quiet(KIND_CHAR, hex_char(4'h9), 1'b0);
    row_quiet(KIND_CHAR, hex_char(4'hA), 1'b0);
    row_quiet(KIND_CHAR, hex_char(4'hF) + 8'd32, 1'b0);
    row_quiet(KIND_CHAR, 8'hFF, 1'b0);
    row_quiet(KIND_TICK, 8'h00, 1'b0);
    row_quiet(KIND_CHAR, CharNewline, 1'b0);
    row_quiet(KIND_CHAR, CharColon, 1'b1);
    row_result(CharNewline, RK_END, 8'h00, 9'd0, 10'd0, 1'b0);
    row_quiet(KIND_CHAR, CharColon, 1'b1);
    row_quiet(KIND_CHAR, hex_char(4'h1), 1'b1);
    row_result(hex_char(4'h2), RK_DATA, 8'h12, 9'd0, 10'd0, 1'b0);
    row_quiet(KIND_CHAR, hex_char(4'h1), 1'b1);
    row_result(hex_char(4'h2), RK_DATA, 8'h12, 9'd1, 10'd0, 1'b0);
    row_quiet(KIND_CHAR, hex_char(4'h7), 1'b1);
    row_result(CharNewline, RK_END, 8'h00, 9'd0, 10'd2, 1'b1);
    row_quiet(KIND_CHAR, CharColon, 1'b1);
    row_quiet(KIND_CHAR, hex_char(4'h5), 1'b1);
    row_result(CharColon, RK_ABORT, 8'h00, 9'd0, 10'd0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) send_word(stim_rows[i].kind, stim_rows[i].ch);
    wait_drained();

    // frame left open across a disabled stretch must resume untouched
    send_word(KIND_CHAR, CharColon);
    send_pair(8'hAB, 1'b1);
    send_digit(4'hC, 1'b1);
    wait_drained();
    write_reg(CFG_PORT_ENABLE, '0);
    repeat (40) begin
      case ($urandom_range(0, 3))
        0: send_word(KIND_CHAR, CharColon);
        1: send_word(KIND_CHAR, CharNewline);
        default: send_word(item_kind_t'($urandom_range(0, 1)), 8'($urandom));
      endcase
    end
    wait_drained();
    write_reg(CFG_PORT_ENABLE, CfgW'(1));
    send_digit(4'hD, 1'b1);
    send_word(KIND_CHAR, CharNewline);
    wait_drained();

    write_reg(CFG_IDLE_LIMIT, CfgW'(1));
    run_random(60);
    wait_drained();

    write_reg(CFG_IDLE_LIMIT, CfgW'(2));
    run_random(60);
    // every position up to the last is streamed, one byte past the limit aborts
    send_long_frame(MaxBytes + 1, 1'b0);
    wait_drained();

    write_reg(CFG_IDLE_LIMIT, CfgW'($urandom_range(3, 20)));
    run_random(60);
    wait_drained();

    // long limit: one tick short survives, a character clears the count
    write_reg(CFG_IDLE_LIMIT, CfgW'(LongIdle));
    send_word(KIND_CHAR, CharColon);
    repeat (LongIdle - 1) send_word(KIND_TICK, 8'($urandom));
    send_pair(8'h12, 1'b1);
    repeat (LongIdle) send_word(KIND_TICK, 8'($urandom));
    run_random(60);
    wait_drained();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
